// ===== rtl/core/latest_state_keyed_journal_defines.svh =====
// Assertion macros for the port-level checker of the keyed journal.
// No dependencies; include once per file that asserts.
`ifndef LATEST_STATE_KEYED_JOURNAL_DEFINES_SVH
`define LATEST_STATE_KEYED_JOURNAL_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define LSKJ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lskj check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define LSKJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lskj check failed");

`endif

// ===== rtl/core/lskj_pkg.sv =====
// Shared types and codes for the latest-state keyed journal.
// No dependencies.
package lskj_pkg;

    localparam int KEY_W   = 64;
    localparam int TICK_W  = 64;
    localparam int KIND_W  = 2;
    localparam int IKIND_W = 3;
    localparam int OCNT_W  = 7;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BADKIND = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic [KIND_W-1:0]  KIND_DISCOVERED = 2'd0;
    localparam logic [IKIND_W-1:0] KIND_MAX        = 3'd3;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TICK_W-1:0] tick;
        logic [KIND_W-1:0] kind;
    } entry_t;

    // Head compare outcome for one scan cycle.
    typedef struct packed {
        logic match;
        logic replace;
    } hit_t;

endpackage

// ===== rtl/core/lskj_cell.sv =====
// One table slot of the rotating entry ring.
// Depends on lskj_pkg.
module lskj_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  logic            load_en,
    input  lskj_pkg::entry_t shift_in,
    input  lskj_pkg::entry_t load_in,
    output lskj_pkg::entry_t entry
);

    logic                             valid_reg;
    logic [lskj_pkg::KEY_W-1:0]       key_reg;
    logic [lskj_pkg::TICK_W-1:0]      tick_reg;
    logic [lskj_pkg::KIND_W-1:0]      kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= shift_in.valid;
        end
        else if (load_en)
        begin
            valid_reg <= load_in.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg  <= shift_in.key;
            tick_reg <= shift_in.tick;
            kind_reg <= shift_in.kind;
        end
        else if (load_en)
        begin
            key_reg  <= load_in.key;
            tick_reg <= load_in.tick;
            kind_reg <= load_in.kind;
        end
    end

    assign entry = '{valid: valid_reg, key: key_reg, tick: tick_reg, kind: kind_reg};

endmodule

// ===== rtl/core/lskj_head.sv =====
// Head comparator: key match and last-writer-wins merge on the entry at slot 0.
// Depends on lskj_pkg.
module lskj_head (
    input  lskj_pkg::entry_t                  head,
    input  logic                              mode,
    input  logic [lskj_pkg::KEY_W-1:0]        key,
    input  logic [lskj_pkg::IKIND_W-1:0]      kind,
    input  logic [lskj_pkg::TICK_W-1:0]       tick,
    output lskj_pkg::entry_t                  wrap,
    output lskj_pkg::hit_t                    hit
);

    logic kind_ok;

    always_comb
    begin
        kind_ok     = (kind <= lskj_pkg::KIND_MAX);
        hit.match   = head.valid && (head.key == key);
        hit.replace = hit.match && (mode == lskj_pkg::MODE_RECORD) && kind_ok &&
                      (tick >= head.tick);
        wrap = head;
        if (hit.replace)
        begin
            wrap.tick = tick;
            wrap.kind = kind[lskj_pkg::KIND_W-1:0];
        end
    end

endmodule

// ===== rtl/core/latest_state_keyed_journal.sv =====
// Top level of the latest-state keyed journal: control, item and result registers,
// and the rotating ring of lskj_cell slots. Depends on lskj_pkg, lskj_cell, lskj_head.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | sink      | in_valid / in_stall | mode, object_id, kind, tick
//  out     | source    | out_valid/out_stall | status, applied, found, stored_kind,
//          |           |                     | stored_tick, active, entry_count
//
// Steps: each item is taken from the input, then makes one full turn of the entry
//   ring past the single head comparator, then goes through a write-back that
//   inserts and loads the result.
// One item at a time; the next transfer is taken once the write-back is done, even
//   while the previous result still waits in the output register.
// A stalled result holds the write-back cycle until the output register frees up.
// Reset clears the slot valid bits, the entry count and control; no clearing pass.
module latest_state_keyed_journal #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [lskj_pkg::KEY_W-1:0]        object_id,
    input  logic [lskj_pkg::IKIND_W-1:0]      kind,
    input  logic [lskj_pkg::TICK_W-1:0]       tick,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic                              applied,
    output logic                              found,
    output logic [lskj_pkg::KIND_W-1:0]       stored_kind,
    output logic [lskj_pkg::TICK_W-1:0]       stored_tick,
    output logic                              active,
    output logic [lskj_pkg::OCNT_W-1:0]       entry_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                         state_reg, state_next;
    logic [IDX_W-1:0]                   scan_reg, scan_next;
    logic [CNT_W-1:0]                   count_reg, count_next;

    // item held for the whole scan
    logic                               mode_reg;
    logic [lskj_pkg::KEY_W-1:0]         key_reg;
    logic [lskj_pkg::IKIND_W-1:0]       kind_reg;
    logic [lskj_pkg::TICK_W-1:0]        tick_reg;

    // what the scan saw at the head
    logic                               hit_found_reg;
    logic                               hit_applied_reg;
    logic [lskj_pkg::KIND_W-1:0]        hit_kind_reg;
    logic [lskj_pkg::TICK_W-1:0]        hit_tick_reg;

    // result register
    logic                               out_valid_reg;
    logic [1:0]                         status_reg;
    logic                               applied_reg;
    logic                               found_reg;
    logic [lskj_pkg::KIND_W-1:0]        skind_reg;
    logic [lskj_pkg::TICK_W-1:0]        stick_reg;
    logic                               active_reg;
    logic [lskj_pkg::OCNT_W-1:0]        ecount_reg;

    lskj_pkg::entry_t                   cell_q [TABLE_DEPTH];
    lskj_pkg::entry_t                   wrap;
    lskj_pkg::entry_t                   ins_entry;
    lskj_pkg::hit_t                     hit;

    logic                               in_fire;
    logic                               out_fire;
    logic                               shift_en;
    logic                               done_fire;
    logic                               kind_bad;
    logic                               table_full;
    logic                               do_insert;
    logic [IDX_W-1:0]                   ins_idx;
    logic [CNT_W+lskj_pkg::OCNT_W-1:0]  count_wide;

    logic [1:0]                         res_status;
    logic                               res_applied;
    logic [lskj_pkg::KIND_W-1:0]        res_kind;
    logic [lskj_pkg::TICK_W-1:0]        res_tick;
    logic                               res_active;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign shift_en  = (state_reg == ST_SCAN);
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign kind_bad   = (kind_reg > lskj_pkg::KIND_MAX);
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_insert  = done_fire && (mode_reg == lskj_pkg::MODE_RECORD) && !kind_bad &&
                        !hit_found_reg && !table_full;
    assign ins_idx    = count_reg[IDX_W-1:0];
    assign ins_entry  = '{valid: 1'b1, key: key_reg, tick: tick_reg,
                          kind: kind_reg[lskj_pkg::KIND_W-1:0]};

    // Ring: slot i takes slot i+1 each scan cycle; slot 0 wraps to the last slot
    // through the head comparator, which merges a record that is not older on the way.
    lskj_head u_head (
        .head (cell_q[0]),
        .mode (mode_reg),
        .key  (key_reg),
        .kind (kind_reg),
        .tick (tick_reg),
        .wrap (wrap),
        .hit  (hit)
    );

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++)
    begin : g_cell
        lskj_pkg::entry_t ring_in;
        if (gi == TABLE_DEPTH - 1)
        begin : g_tail
            assign ring_in = wrap;
        end
        else
        begin : g_mid
            assign ring_in = cell_q[gi + 1];
        end

        lskj_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .load_en  (do_insert && (ins_idx == IDX_W'(gi))),
            .shift_in (ring_in),
            .load_in  (ins_entry),
            .entry    (cell_q[gi])
        );
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_next = '0;
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + IDX_W'(1);
                if (scan_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result assembly in the write-back cycle
    always_comb
    begin
        count_next = count_reg + CNT_W'(do_insert);
        count_wide = {{lskj_pkg::OCNT_W{1'b0}}, count_next};

        if (mode_reg == lskj_pkg::MODE_QUERY)
        begin
            res_status = lskj_pkg::STATUS_OK;
        end
        else if (kind_bad)
        begin
            res_status = lskj_pkg::STATUS_BADKIND;
        end
        else if (!hit_found_reg && table_full)
        begin
            res_status = lskj_pkg::STATUS_FULL;
        end
        else
        begin
            res_status = lskj_pkg::STATUS_OK;
        end

        if (hit_found_reg)
        begin
            res_applied = hit_applied_reg;
            res_kind    = hit_kind_reg;
            res_tick    = hit_tick_reg;
        end
        else if (do_insert)
        begin
            res_applied = 1'b1;
            res_kind    = kind_reg[lskj_pkg::KIND_W-1:0];
            res_tick    = tick_reg;
        end
        else
        begin
            res_applied = 1'b0;
            res_kind    = '0;
            res_tick    = '0;
        end
        res_active = (hit_found_reg || do_insert) && (res_kind == lskj_pkg::KIND_DISCOVERED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            if (done_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and scan capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg        <= mode;
            key_reg         <= object_id;
            kind_reg        <= kind;
            tick_reg        <= tick;
            hit_found_reg   <= 1'b0;
            hit_applied_reg <= 1'b0;
        end
        else if (shift_en && hit.match)
        begin
            hit_found_reg   <= 1'b1;
            hit_applied_reg <= hit.replace;
            hit_kind_reg    <= wrap.kind;
            hit_tick_reg    <= wrap.tick;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            status_reg  <= res_status;
            applied_reg <= res_applied;
            found_reg   <= hit_found_reg;
            skind_reg   <= res_kind;
            stick_reg   <= res_tick;
            active_reg  <= res_active;
            ecount_reg  <= count_wide[lskj_pkg::OCNT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign applied     = applied_reg;
    assign found       = found_reg;
    assign stored_kind = skind_reg;
    assign stored_tick = stick_reg;
    assign active      = active_reg;
    assign entry_count = ecount_reg;

endmodule

// ===== rtl/core/lskj_checker.sv =====
// Port-level checks for the keyed journal, bound to the top level.
// Depends on lskj_pkg and latest_state_keyed_journal_defines.svh.
`include "latest_state_keyed_journal_defines.svh"

module lskj_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [1:0]                        status,
    input logic                              applied,
    input logic                              found,
    input logic [lskj_pkg::KIND_W-1:0]       stored_kind,
    input logic [lskj_pkg::TICK_W-1:0]       stored_tick,
    input logic                              active
);

    // held result stays put
    `LSKJ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(stored_tick) && $stable(status))

    // one item in flight: a transfer closes the input at once
    `LSKJ_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

    // refused records never apply
    `LSKJ_ASSERT_NOW(a_refused, clk, rst_n, out_valid && (status == lskj_pkg::STATUS_BADKIND || status == lskj_pkg::STATUS_FULL), !applied)

    // a full table only refuses new ids
    `LSKJ_ASSERT_NOW(a_full_new, clk, rst_n, out_valid && status == lskj_pkg::STATUS_FULL, !found)

    // active only for a held, discovered entry
    `LSKJ_ASSERT_NOW(a_active, clk, rst_n, out_valid && active, (found || applied) && stored_kind == lskj_pkg::KIND_DISCOVERED)

endmodule

bind latest_state_keyed_journal lskj_checker u_lskj_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .applied     (applied),
    .found       (found),
    .stored_kind (stored_kind),
    .stored_tick (stored_tick),
    .active      (active)
);

// ===== test/latest_state_keyed_journal_checker.sv =====
// Checker for the latest-state keyed journal: watches both channels, keeps its own
// copy of the keyed table, and compares every result transfer with the oldest prediction.
// Depends on lskj_pkg.
module latest_state_keyed_journal_checker #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         mode,
    input  logic [lskj_pkg::KEY_W-1:0]   object_id,
    input  logic [lskj_pkg::IKIND_W-1:0] kind,
    input  logic [lskj_pkg::TICK_W-1:0]  tick,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [1:0]                   status,
    input  logic                         applied,
    input  logic                         found,
    input  logic [lskj_pkg::KIND_W-1:0]  stored_kind,
    input  logic [lskj_pkg::TICK_W-1:0]  stored_tick,
    input  logic                         active,
    input  logic [lskj_pkg::OCNT_W-1:0]  entry_count,
    output int                           mismatches,
    output int                           results_pending,
    output int                           results_seen,
    output int                           full_refusals,
    output int                           kind_refusals,
    output int                           stale_ignored
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOWN_LIMIT = 10;

    typedef struct packed {
        logic [1:0]                  status;
        logic                        applied;
        logic                        found;
        logic [lskj_pkg::KIND_W-1:0] stored_kind;
        logic [lskj_pkg::TICK_W-1:0] stored_tick;
        logic                        active;
        logic [lskj_pkg::OCNT_W-1:0] entry_count;
    } journal_result_t;

    // shadow table: slots 0..slots_used-1 are live, filled in arrival order
    logic [lskj_pkg::KEY_W-1:0]  slot_id   [DEPTH];
    logic [lskj_pkg::TICK_W-1:0] slot_tick [DEPTH];
    logic [lskj_pkg::KIND_W-1:0] slot_kind [DEPTH];
    logic                        slot_live [DEPTH];
    int                          slots_used;

    journal_result_t   pending_results [$];
    journal_result_t   want;
    journal_result_t   got;
    int                mismatch_n;
    int                seen_n;
    int                full_n;
    int                badkind_n;
    int                stale_n;

    // Apply one item to the shadow table and return the result it should produce.
    function automatic journal_result_t apply_journal_item(
        input logic                         m,
        input logic [lskj_pkg::KEY_W-1:0]   id,
        input logic [lskj_pkg::IKIND_W-1:0] k,
        input logic [lskj_pkg::TICK_W-1:0]  t
    );
        journal_result_t r;
        int              hit;
        int              i;
        r = '0;
        hit = -1;
        for (i = 0; i < DEPTH; i++)
        begin
            if (hit < 0 && slot_live[i] && slot_id[i] == id)
                hit = i;
        end
        r.status = lskj_pkg::STATUS_OK;
        r.found  = (hit >= 0);
        if (m == lskj_pkg::MODE_RECORD)
        begin
            if (k > lskj_pkg::KIND_MAX)
                r.status = lskj_pkg::STATUS_BADKIND;
            else if (hit < 0)
            begin
                if (slots_used >= DEPTH)
                    r.status = lskj_pkg::STATUS_FULL;
                else
                begin
                    hit = slots_used;
                    slot_id[hit]   = id;
                    slot_tick[hit] = t;
                    slot_kind[hit] = k[lskj_pkg::KIND_W-1:0];
                    slot_live[hit] = 1'b1;
                    slots_used++;
                    r.applied = 1'b1;
                end
            end
            else if (t >= slot_tick[hit])
            begin
                // last writer wins, ties included
                slot_tick[hit] = t;
                slot_kind[hit] = k[lskj_pkg::KIND_W-1:0];
                r.applied = 1'b1;
            end
        end
        if (hit >= 0)
        begin
            r.stored_kind = slot_kind[hit];
            r.stored_tick = slot_tick[hit];
            r.active      = (slot_kind[hit] == lskj_pkg::KIND_DISCOVERED);
        end
        r.entry_count = lskj_pkg::OCNT_W'(slots_used);
        return r;
    endfunction

    task automatic show_result(input string label, input journal_result_t r);
        $display("  %s status=%0d applied=%0d found=%0d kind=%0d tick=%h active=%0d count=%0d",
                 label, r.status, r.applied, r.found, r.stored_kind, r.stored_tick,
                 r.active, r.entry_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < DEPTH; i++)
                slot_live[i] = 1'b0;
            slots_used = 0;
            pending_results.delete();
            mismatch_n = 0;
            seen_n     = 0;
            full_n     = 0;
            badkind_n  = 0;
            stale_n    = 0;
        end
        else
        begin
            // result side first: a result never belongs to the item taken at the same edge
            if (out_valid && !out_stall)
            begin
                seen_n++;
                got = {status, applied, found, stored_kind, stored_tick, active, entry_count};
                if (pending_results.size() == 0)
                begin
                    mismatch_n++;
                    if (mismatch_n <= SHOWN_LIMIT)
                    begin
                        $display("%0t: result transfer %0d with nothing expected", $time, seen_n);
                        show_result("got", got);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_n++;
                        if (mismatch_n <= SHOWN_LIMIT)
                        begin
                            $display("%0t: result transfer %0d differs", $time, seen_n);
                            show_result("exp", want);
                            show_result("got", got);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want = apply_journal_item(mode, object_id, kind, tick);
                if (want.status == lskj_pkg::STATUS_FULL)
                    full_n++;
                if (want.status == lskj_pkg::STATUS_BADKIND)
                    badkind_n++;
                if (mode == lskj_pkg::MODE_RECORD && want.status == lskj_pkg::STATUS_OK &&
                    !want.applied)
                    stale_n++;
                pending_results = {pending_results, want};
            end
        end
        mismatches      <= mismatch_n;
        results_pending <= pending_results.size();
        results_seen    <= seen_n;
        full_refusals   <= full_n;
        kind_refusals   <= badkind_n;
        stale_ignored   <= stale_n;
    end

endmodule

// ===== test/latest_state_keyed_journal_tb.sv =====
// Top of the keyed journal testbench: clock, reset, stimulus, receiver stalls, watchdog
// and the verdict. Depends on lskj_pkg, latest_state_keyed_journal and its checker.
module latest_state_keyed_journal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = 64;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    // one item is a full ring turn plus take and write-back; leave some slack
    localparam int DRAIN_TAIL     = TABLE_DEPTH + 16;
    // long receiver hold-off, used once to back the block up into its input
    localparam int LONG_HOLD      = 400;
    // no transfer for this long means a hang; the longest legal quiet stretch is the hold
    localparam int WATCHDOG_LIMIT = 10 * LONG_HOLD;
    // more keys than slots, so the table fills and capacity refusals show up late in the run
    localparam int POOL_SIZE      = 80;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic                           mode      = lskj_pkg::MODE_RECORD;
    logic [lskj_pkg::KEY_W-1:0]     object_id = '0;
    logic [lskj_pkg::IKIND_W-1:0]   kind      = '0;
    logic [lskj_pkg::TICK_W-1:0]    tick      = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [1:0]                     status;
    logic                           applied;
    logic                           found;
    logic [lskj_pkg::KIND_W-1:0]    stored_kind;
    logic [lskj_pkg::TICK_W-1:0]    stored_tick;
    logic                           active;
    logic [lskj_pkg::OCNT_W-1:0]    entry_count;

    // from the checker
    int mismatches;
    int results_pending;
    int results_seen;
    int full_refusals;
    int kind_refusals;
    int stale_ignored;

    // pacing knobs, percent per cycle
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    // hold-off requests are counted here and served by the receiver process
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int quiet_cycles  = 0;
    int items_sent    = 0;

    logic [lskj_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    latest_state_keyed_journal #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (.*);

    latest_state_keyed_journal_checker #(
        .DEPTH (TABLE_DEPTH)
    ) i_checker (.*);

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one has been requested.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            out_stall   <= 1'b1;
            hold_left   <= LONG_HOLD;
            hold_served <= hold_requests;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Watchdog: any transfer on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                         quiet_cycles, results_pending);
                $display("latest_state_keyed_journal_tb: FAIL");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the block takes the transfer.
    // Returns in the time step of the accepting edge.
    task automatic send_item(
        input logic                         m,
        input logic [lskj_pkg::KEY_W-1:0]   id,
        input logic [lskj_pkg::IKIND_W-1:0] k,
        input logic [lskj_pkg::TICK_W-1:0]  t
    );
        mode      <= m;
        object_id <= id;
        kind      <= k;
        tick      <= t;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        // the count seen here is registered in the checker, so step past the last transfer first
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // Random items. Keys come mostly from the pool, so the same ids are hit again and
    // again; ticks are mostly tiny so equal and older ticks are common. Fresh random ids
    // go in as queries only, unless wide_records lets them insert too.
    task automatic run_phase(
        input int          count,
        input int unsigned tx_pct,
        input int unsigned rx_pct,
        input int          key_span,
        input bit          wide_records
    );
        logic                         m;
        logic [lskj_pkg::KEY_W-1:0]   id;
        logic [lskj_pkg::IKIND_W-1:0] k;
        logic [lskj_pkg::TICK_W-1:0]  t;
        int                           n;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (n = 0; n < count; n++)
        begin
            m = ($urandom_range(0, 9) < 3) ? lskj_pkg::MODE_QUERY : lskj_pkg::MODE_RECORD;
            if ($urandom_range(0, 19) < 3)
            begin
                id = {$urandom, $urandom};
                if (!wide_records)
                    m = lskj_pkg::MODE_QUERY;
            end
            else
                id = key_pool[$urandom_range(0, key_span - 1)];
            if ($urandom_range(0, 9) < 8)
                k = lskj_pkg::IKIND_W'($urandom_range(0, 3));
            else
                k = lskj_pkg::IKIND_W'($urandom_range(4, 7));
            case ($urandom_range(0, 19))
                0:                t = '0;
                1:                t = '1;
                2, 3, 4, 5, 6, 7: t = {$urandom, $urandom};
                default:          t = lskj_pkg::TICK_W'($urandom_range(0, 15));
            endcase
            send_item(m, id, k, t);
            // geometric sender gaps; valid only drops in a step where it is not raised
            while ($urandom_range(0, 99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        int n;
        // pool: extremes, one random id and two neighbors that differ in a single end bit
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = {$urandom, $urandom};
        key_pool[3] = key_pool[2] ^ 64'h1;
        key_pool[4] = key_pool[2] ^ {1'b1, 63'h0};
        for (n = 5; n < POOL_SIZE; n++)
            key_pool[n] = {$urandom, $urandom};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, back to back ----
        // query on the empty table: nothing found, all-zero report
        send_item(lskj_pkg::MODE_QUERY,  key_pool[0], 3'd0, '0);
        // first inserts at the field extremes
        send_item(lskj_pkg::MODE_RECORD, key_pool[0], 3'd0, '0);
        send_item(lskj_pkg::MODE_RECORD, key_pool[1], 3'd3, '1);
        // query ignores its kind and tick inputs
        send_item(lskj_pkg::MODE_QUERY,  key_pool[0], 3'd7, '1);
        send_item(lskj_pkg::MODE_QUERY,  key_pool[1], 3'd0, '0);
        // equal tick replaces
        send_item(lskj_pkg::MODE_RECORD, key_pool[0], 3'd1, '0);
        // older tick is dropped without error
        send_item(lskj_pkg::MODE_RECORD, key_pool[1], 3'd0, 64'd5);
        // invalid kind on a held id reports the entry, changes nothing
        send_item(lskj_pkg::MODE_RECORD, key_pool[0], 3'd7, '1);
        // invalid kind on an absent id
        send_item(lskj_pkg::MODE_RECORD, key_pool[2], 3'd4, 64'd1);
        send_item(lskj_pkg::MODE_RECORD, key_pool[2], 3'd2, {1'b1, 63'h0});
        // one-bit neighbors must land in slots of their own
        send_item(lskj_pkg::MODE_RECORD, key_pool[3], 3'd0, 64'd1);
        send_item(lskj_pkg::MODE_RECORD, key_pool[4], 3'd1, 64'd2);
        send_item(lskj_pkg::MODE_QUERY,  key_pool[2], 3'd0, '0);
        send_item(lskj_pkg::MODE_QUERY,  key_pool[3], 3'd5, 64'd9);
        send_item(lskj_pkg::MODE_QUERY,  key_pool[4], 3'd6, '1);
        // older by one in the top half, then a newer tick back to discovered
        send_item(lskj_pkg::MODE_RECORD, key_pool[2], 3'd3, {1'b0, {63{1'b1}}});
        send_item(lskj_pkg::MODE_RECORD, key_pool[2], 3'd0, '1);
        send_item(lskj_pkg::MODE_RECORD, key_pool[3], 3'd5, 64'd3);
        send_item(lskj_pkg::MODE_RECORD, key_pool[3], 3'd6, 64'd0);
        // absent random id
        send_item(lskj_pkg::MODE_QUERY,  {$urandom, $urandom}, 3'd0, '0);

        // ---- random part, key span widening phase by phase ----
        run_phase(180,  0,  0, 24, 1'b0);
        run_phase(180, 64,  0, 40, 1'b0);
        run_phase(180,  0, 64, 56, 1'b0);
        // from here the table fills and inserts of new ids are refused
        run_phase(180, 10, 10, POOL_SIZE, 1'b1);

        // receiver holds off for a long stretch while the sender keeps offering
        hold_requests <= hold_requests + 1;
        run_phase(60, 0, 0, POOL_SIZE, 1'b1);

        // sender pauses until the block has handed back everything
        drain_results();
        run_phase(30, 10, 10, POOL_SIZE, 1'b1);

        drain_results();
        rx_stall_pct = 0;
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("summary: %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("summary: %0d table-full refusals, %0d bad-kind refusals, %0d stale ticks",
                 full_refusals, kind_refusals, stale_ignored);
        if (mismatches == 0 && results_pending == 0)
            $display("latest_state_keyed_journal_tb: PASS");
        else
            $display("latest_state_keyed_journal_tb: FAIL");
        $finish;
    end

endmodule
